// ----- rtl/s256_pkg.sv -----
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, constants and functions for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package s256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned PadStart   = 56;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;
	typedef logic [63:0] bits_t;

	typedef struct packed {
		logic  load_byte;
		logic  load_pad;
		logic  load_len;
		logic  [5:0] wr_addr;
		byte_t wr_data;
		logic  start_block;
		logic  do_round;
		logic  finish_block;
		logic  restart;
		logic  add_block_bits;
		logic  [5:0] round_idx;
		logic  [2:0] out_idx;
	} s256_cmd_t;

	typedef struct packed {
		logic [6:0] fill;
		bits_t      msg_bits;
		word_t      out_word;
	} s256_stat_t;

	localparam word_t InitWords [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t round_k(input logic [5:0] r);
		word_t k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ----- rtl/s256_if.sv -----
// ----------------------------------------------------------------------------
// s256_in_if / s256_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface s256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_last;
	modport source (output valid, data_byte, has_byte, is_last, input ready);
	modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface s256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/s256_datapath.sv -----
// ----------------------------------------------------------------------------
// s256_datapath
// Schedule window (also holds the block bytes), round registers, chain words
// and bit count.
// ----------------------------------------------------------------------------
`default_nettype none
module s256_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  s256_pkg::s256_cmd_t  cmd,
	output s256_pkg::s256_stat_t stat
);
	import s256_pkg::*;

	word_t      w_q [16];
	word_t      v_q [8];
	word_t      h_q [8];
	logic [6:0] fill_q;
	bits_t      bits_q;

	word_t w_cur, w_new, s0, s1, t1, t2, a, e;

	always_comb begin
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = (cmd.round_idx < 6'd16) ? w_q[0] : w_new;
		a     = v_q[0];
		e     = v_q[4];
		t1    = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(cmd.round_idx) + w_cur;
		t2    = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte || cmd.load_pad || cmd.load_len) begin
			w_q[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
		end else if (cmd.do_round) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
		end
		if (cmd.start_block) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (cmd.do_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= e;
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= a;
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				h_q[i] <= InitWords[i];
			fill_q <= '0;
			bits_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++)
					h_q[i] <= InitWords[i];
				fill_q <= '0;
				bits_q <= '0;
			end else begin
				if (cmd.finish_block) begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
				end
				if (cmd.load_byte)
					fill_q <= fill_q + 7'd1;
				else if (cmd.add_block_bits) begin
					fill_q <= '0;
					bits_q <= bits_q + 64'd512;
				end
			end
		end
	end

	assign stat.fill     = fill_q;
	assign stat.msg_bits = bits_q;
	assign stat.out_word = h_q[cmd.out_idx];
endmodule
`default_nettype wire

// ----- rtl/s256_ctrl.sv -----
// ----------------------------------------------------------------------------
// s256_ctrl
// Sequencer: byte intake, padding, rounds and digest word output.
// ----------------------------------------------------------------------------
`default_nettype none
module s256_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	s256_in_if.sink              in_ch,
	s256_out_if.source           out_ch,
	output s256_pkg::s256_cmd_t  cmd,
	input  s256_pkg::s256_stat_t stat
);
	import s256_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCHED = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_FIN   = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_LEN   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       last_q;
	logic       final_q;
	logic       mark_q;
	bits_t      total_q;
	logic [2:0] oidx_q;
	logic       acc;

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign acc                = in_ch.valid && in_ch.ready;
	assign out_ch.valid       = (state_q == ST_OUT);
	assign out_ch.digest_word = stat.out_word;
	assign out_ch.word_index  = oidx_q;
	assign out_ch.last_word   = (oidx_q == 3'd7);

	always_comb begin
		cmd = '0;
		cmd.round_idx = cnt_q;
		cmd.out_idx   = oidx_q;
		cmd.wr_addr   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load_byte = acc && in_ch.has_byte;
				cmd.wr_addr   = stat.fill[5:0];
				cmd.wr_data   = in_ch.data_byte;
			end
			ST_SCHED: cmd.start_block = 1'b1;
			ST_ROUND: cmd.do_round = 1'b1;
			ST_FIN: begin
				cmd.finish_block   = 1'b1;
				cmd.add_block_bits = !last_q || mark_q;
			end
			ST_PAD: begin
				cmd.load_pad = 1'b1;
				cmd.wr_data  = mark_q ? 8'h80 : 8'h00;
			end
			ST_LEN: begin
				cmd.load_len = 1'b1;
				cmd.wr_data  = total_q[63 - 8*(cnt_q[2:0]) -: 8];
				cmd.wr_addr  = {3'b111, cnt_q[2:0]};
			end
			ST_OUT: cmd.restart = out_ch.ready && (oidx_q == 3'd7);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			final_q <= 1'b0;
			mark_q  <= 1'b0;
			total_q <= '0;
			oidx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (acc) begin
					if (in_ch.has_byte && stat.fill == 7'd63) begin
						last_q  <= in_ch.is_last;
						mark_q  <= in_ch.is_last;
						final_q <= 1'b0;
						total_q <= stat.msg_bits + 64'd512;
						state_q <= ST_SCHED;
					end else if (in_ch.is_last) begin
						last_q  <= 1'b1;
						mark_q  <= 1'b1;
						final_q <= 1'b0;
						total_q <= stat.msg_bits
							+ {54'd0, stat.fill + {6'd0, in_ch.has_byte}, 3'd0};
						cnt_q   <= stat.fill[5:0] + {5'd0, in_ch.has_byte};
						state_q <= ST_PAD;
					end
				end
				ST_SCHED: begin
					cnt_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					cnt_q <= '0;
					if (!last_q)
						state_q <= ST_IDLE;
					else if (final_q) begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end else
						state_q <= ST_PAD;
				end
				ST_PAD: begin
					mark_q <= 1'b0;
					if (cnt_q == 6'd55) begin
						cnt_q   <= '0;
						state_q <= ST_LEN;
					end else if (cnt_q == 6'd63)
						state_q <= ST_SCHED;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				ST_LEN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[2:0] == 3'd7) begin
						final_q <= 1'b1;
						state_q <= ST_SCHED;
					end
				end
				ST_OUT: if (out_ch.ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						last_q  <= 1'b0;
						final_q <= 1'b0;
						mark_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sha256_byte_stream_hasher_top.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream; emits eight digest words per message.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   data_byte, has_byte, is_last
//  out_ch   out  digest_word, word_index, last_word
//
//  A byte that does not fill a block is written while idle, and the input stays ready.
//  A full block goes through the byte, working variable load, 64 rounds and
//  chain update.
//  A last item adds padding writes, one or two blocks, and eight output
//  transactions; output stalls hold the block.
//  Reset returns the chain words, fill and bit count to their initial values.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_byte_stream_hasher_top (
	input wire         clk,
	input wire         arst_n,
	s256_in_if.sink    in_ch,
	s256_out_if.source out_ch
);
	import s256_pkg::*;

	s256_cmd_t  cmd;
	s256_stat_t stat;

	s256_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cmd(cmd), .stat(stat)
	);

	s256_datapath u_dp (.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat));
endmodule
`default_nettype wire
